### rtl/core/fcd_pkg.sv
// fcd_pkg: widths, register indexes and reset values of the frame change detector
// no dependencies; imported by the core, its port checker, the frame checker and the testbench
`timescale 1ns / 1ps

package fcd_pkg;

  // frame size bound, log2 of the largest pixel count
  localparam int unsigned MAX_PIXELS_LOG2 = 22;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CNT_W  = MAX_PIXELS_LOG2 + 1;
  localparam int unsigned SUM_W  = MAX_PIXELS_LOG2 + PIX_W;
  localparam int unsigned MEAN_W = 16;
  // mean_q8 * count, also holds {sum, 8'b0} with one spare top bit
  localparam int unsigned PROD_W = MEAN_W + CNT_W;

  localparam int unsigned IN_TDATA_W   = 2 * PIX_W;
  localparam int unsigned OUT_FIELDS_W = 1 + CNT_W + SUM_W + CNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned CFG_W     = (CNT_W > MEAN_W) ? CNT_W : MEAN_W;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_DELTA = 2'd0,
    REG_MIN_CHANGED = 2'd1,
    REG_MEAN_DELTA  = 2'd2
  } cfg_reg_e;

  localparam logic [PIX_W-1:0]  PIXEL_DELTA_RST = PIX_W'(16);
  localparam logic [CNT_W-1:0]  MIN_CHANGED_RST = CNT_W'(1024);
  localparam logic [MEAN_W-1:0] MEAN_DELTA_RST  = MEAN_W'(1280);

endpackage

### rtl/core/frame_change_detector.sv
// frame_change_detector: frame difference change detection over a stream of pixel pairs
// depends on fcd_pkg
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+------------------------------------------
//  s_axis    | in  | tvalid/tready         | tdata: before, after; tuser: sizes_differ;
//            |     |                       | tlast: last pixel pair of the frame
//  m_axis    | out | tvalid/tready         | tdata: frame_changed, changed_pixels,
//            |     |                       | sum_abs_delta, pixel_count (one per frame)
//  cfg       | in  | cfg_we_i, no stall    | cfg_idx_i selects, cfg_data_i written
//
// one pixel pair per clock is accepted, sustained, as long as results are taken
// a frame's result reaches m_axis after its accepted last pair passes the input register,
// accumulators into snapshot, multiplier stage (mean_q8 * count), result register
// reset clears accumulators and pipeline valids and loads the register defaults
// a stalled result holds only the last-pair path; other pairs keep accumulating
`timescale 1ns / 1ps

module frame_change_detector
  import fcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // before_pixel, after_pixel
  input  logic                   s_axis_tuser,   // sizes_differ
  input  logic                   s_axis_tlast,   // last_pixel

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // frame_changed, changed_pixels,
                                                 // sum_abs_delta, pixel_count, zero pad
);

  // configuration registers
  logic [PIX_W-1:0]  pixel_delta_q;
  logic [CNT_W-1:0]  min_changed_q;
  logic [MEAN_W-1:0] mean_delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_delta_q <= PIXEL_DELTA_RST;
      min_changed_q <= MIN_CHANGED_RST;
      mean_delta_q  <= MEAN_DELTA_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PIXEL_DELTA: pixel_delta_q <= cfg_data_i[PIX_W-1:0];
        REG_MIN_CHANGED: min_changed_q <= cfg_data_i[CNT_W-1:0];
        REG_MEAN_DELTA:  mean_delta_q  <= cfg_data_i[MEAN_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake, ready flows back from the result register
  logic in_vld_q, snap_vld_q, prod_vld_q, out_vld_q;
  logic in_last_q;
  logic out_rdy, prod_adv, prod_rdy, snap_adv, snap_rdy, in_adv, snap_load;

  assign out_rdy   = !out_vld_q || m_axis_tready;
  assign prod_adv  = prod_vld_q && out_rdy;
  assign prod_rdy  = !prod_vld_q || prod_adv;
  assign snap_adv  = snap_vld_q && prod_rdy;
  assign snap_rdy  = !snap_vld_q || snap_adv;
  // a non-last pair never needs the result path
  assign in_adv    = in_vld_q && (!in_last_q || snap_rdy);
  assign snap_load = in_adv && in_last_q;

  assign s_axis_tready = !in_vld_q || in_adv;

  // ---------------------------------------------------------------------------
  // input register
  logic [PIX_W-1:0] in_before_q, in_after_q;
  logic             in_differ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_before_q <= s_axis_tdata[PIX_W-1:0];
      in_after_q  <= s_axis_tdata[2*PIX_W-1:PIX_W];
      in_differ_q <= s_axis_tuser;
      in_last_q   <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // accumulators: absolute difference, saturating sum and counts
  logic [PIX_W-1:0] abs_delta;
  logic             pix_changed;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] pair_q, pair_d, chg_q, chg_d;

  assign abs_delta   = (in_before_q >= in_after_q) ? (in_before_q - in_after_q)
                                                   : (in_after_q - in_before_q);
  assign pix_changed = abs_delta > pixel_delta_q;
  assign sum_wide    = {1'b0, sum_q} + (SUM_W+1)'(abs_delta);

  always_comb begin
    sum_d  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    pair_d = (pair_q == '1) ? pair_q : pair_q + 1'b1;
    chg_d  = (pix_changed && (chg_q != '1)) ? chg_q + 1'b1 : chg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pair_q <= '0;
      chg_q  <= '0;
    end else if (in_adv) begin
      if (in_last_q) begin
        // frame closed, totals move to the snapshot
        sum_q  <= '0;
        pair_q <= '0;
        chg_q  <= '0;
      end else begin
        sum_q  <= sum_d;
        pair_q <= pair_d;
        chg_q  <= chg_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // frame snapshot, totals including the last pair
  logic [SUM_W-1:0] snap_sum_q;
  logic [CNT_W-1:0] snap_pair_q, snap_chg_q;
  logic             snap_differ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
    end else if (snap_load) begin
      snap_vld_q <= 1'b1;
    end else if (snap_adv) begin
      snap_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      snap_sum_q    <= sum_d;
      snap_pair_q   <= pair_d;
      snap_chg_q    <= chg_d;
      snap_differ_q <= in_differ_q;
    end
  end

  // ---------------------------------------------------------------------------
  // multiplier stage: threshold times count, count and size tests
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W-1:0]  prod_sum_q;
  logic [CNT_W-1:0]  prod_pair_q, prod_chg_q;
  logic              prod_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else if (prod_rdy) begin
      prod_vld_q <= snap_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv) begin
      prod_q      <= PROD_W'(mean_delta_q) * PROD_W'(snap_pair_q);
      prod_sum_q  <= snap_sum_q;
      prod_pair_q <= snap_pair_q;
      prod_chg_q  <= snap_chg_q;
      prod_flag_q <= snap_differ_q || (snap_chg_q >= min_changed_q);
    end
  end

  // ---------------------------------------------------------------------------
  // result register, mean test as sum*256 > mean_q8*count
  logic              mean_over;
  logic              out_flag_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic [CNT_W-1:0]  out_pair_q, out_chg_q;

  assign mean_over = {1'b0, prod_sum_q, 8'b0} > prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_adv) begin
      out_flag_q <= prod_flag_q || mean_over;
      out_sum_q  <= prod_sum_q;
      out_pair_q <= prod_pair_q;
      out_chg_q  <= prod_chg_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_pair_q, out_sum_q, out_chg_q, out_flag_q});

endmodule

### rtl/core/fcd_port_checker.sv
// fcd_port_checker: port-level checks on the frame change detector result stream
// depends on fcd_pkg; bound to frame_change_detector below
`timescale 1ns / 1ps

module fcd_port_checker
  import fcd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [CNT_W-1:0] res_chg, res_pair;
  logic [SUM_W-1:0] res_sum;

  assign res_chg  = m_axis_tdata[CNT_W:1];
  assign res_sum  = m_axis_tdata[CNT_W+SUM_W:CNT_W+1];
  assign res_pair = m_axis_tdata[2*CNT_W+SUM_W:CNT_W+SUM_W+1];

  // stalled result stays offered and unchanged
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // every frame holds at least its last pair
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_pair != '0)
    else $error("empty frame reported");

  a_chg_le_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res_chg <= res_pair)
    else $error("changed count above pixel count");

  // each pair adds at most full scale to the sum
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 64'(res_sum) <= 64'(res_pair) * 64'd255)
    else $error("sum above full scale times count");

endmodule

bind frame_change_detector fcd_port_checker u_fcd_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/fcd_frame_checker.sv
// fcd_frame_checker: watches the cfg port and both streams of frame_change_detector,
// predicts each frame result and compares it field by field; depends on fcd_pkg
`timescale 1ns / 1ps

module fcd_frame_checker
  import fcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,

  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // before_pixel, after_pixel
  input  logic                   s_axis_tuser,   // sizes_differ
  input  logic                   s_axis_tlast,   // last_pixel

  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // frame_changed, changed_pixels,
                                                 // sum_abs_delta, pixel_count, zero pad

  output int unsigned            pending_o,
  output int unsigned            mismatches_o
);

  localparam int unsigned CHG_LSB = 1;
  localparam int unsigned SUM_LSB = 1 + CNT_W;
  localparam int unsigned CNT_LSB = 1 + CNT_W + SUM_W;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic             flagged;
    logic [CNT_W-1:0] changed_px;
    logic [SUM_W-1:0] delta_sum;
    logic [CNT_W-1:0] pairs;
  } frame_summary_t;

  logic [PIX_W-1:0]  pixel_delta_q;
  logic [CNT_W-1:0]  min_changed_q;
  logic [MEAN_W-1:0] mean_q8_q;

  logic [SUM_W-1:0]  sum_acc;
  logic [CNT_W-1:0]  changed_acc;
  logic [CNT_W-1:0]  pairs_acc;

  frame_summary_t    expected_frames_q[$];
  int unsigned       mismatches;

  function automatic logic [63:0] sat_add(logic [63:0] acc, logic [63:0] add,
                                          logic [63:0] cap);
    if (acc >= cap || add > cap - acc) return cap;
    return acc + add;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // fold one pixel pair into the running frame, close the frame on last
  task automatic absorb_pair(logic [PIX_W-1:0] before_px, logic [PIX_W-1:0] after_px,
                             logic differ, logic last);
    logic [PIX_W-1:0] d;
    logic [63:0]      sum_q8;
    logic [63:0]      bound;
    frame_summary_t   fr;
    d = (before_px >= after_px) ? before_px - after_px : after_px - before_px;
    sum_acc   = SUM_W'(sat_add(64'(sum_acc), 64'(d), 64'({SUM_W{1'b1}})));
    pairs_acc = CNT_W'(sat_add(64'(pairs_acc), 64'd1, 64'({CNT_W{1'b1}})));
    if (d > pixel_delta_q)
      changed_acc = CNT_W'(sat_add(64'(changed_acc), 64'd1, 64'({CNT_W{1'b1}})));
    if (last) begin
      // mean test without division: sum * 256 > mean_q8 * count
      sum_q8 = 64'(sum_acc) << 8;
      bound  = 64'(mean_q8_q) * 64'(pairs_acc);
      fr.flagged    = differ || (changed_acc >= min_changed_q) || (sum_q8 > bound);
      fr.changed_px = changed_acc;
      fr.delta_sum  = sum_acc;
      fr.pairs      = pairs_acc;
      expected_frames_q.push_back(fr);
      sum_acc     = '0;
      changed_acc = '0;
      pairs_acc   = '0;
    end
  endtask

  task automatic check_frame(logic [OUT_TDATA_W-1:0] tdata);
    frame_summary_t fr;
    if (expected_frames_q.size() == 0) begin
      note_mismatch("unexpected result item", 64'd0, 64'(tdata));
    end else begin
      fr = expected_frames_q.pop_front();
      if (tdata[0] !== fr.flagged)
        note_mismatch("frame_changed", 64'(fr.flagged), 64'(tdata[0]));
      if (tdata[CHG_LSB +: CNT_W] !== fr.changed_px)
        note_mismatch("changed_pixels", 64'(fr.changed_px), 64'(tdata[CHG_LSB +: CNT_W]));
      if (tdata[SUM_LSB +: SUM_W] !== fr.delta_sum)
        note_mismatch("sum_abs_delta", 64'(fr.delta_sum), 64'(tdata[SUM_LSB +: SUM_W]));
      if (tdata[CNT_LSB +: CNT_W] !== fr.pairs)
        note_mismatch("pixel_count", 64'(fr.pairs), 64'(tdata[CNT_LSB +: CNT_W]));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_delta_q = PIXEL_DELTA_RST;
      min_changed_q = MIN_CHANGED_RST;
      mean_q8_q     = MEAN_DELTA_RST;
      sum_acc       = '0;
      changed_acc   = '0;
      pairs_acc     = '0;
      expected_frames_q.delete();
      mismatches    = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PIXEL_DELTA: pixel_delta_q = cfg_data_i[PIX_W-1:0];
          REG_MIN_CHANGED: min_changed_q = cfg_data_i[CNT_W-1:0];
          REG_MEAN_DELTA:  mean_q8_q     = cfg_data_i[MEAN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_pair(s_axis_tdata[PIX_W-1:0], s_axis_tdata[2*PIX_W-1:PIX_W],
                    s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        check_frame(m_axis_tdata);
      pending_o    <= expected_frames_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

### dv/tb_frame_change_detector.sv
// tb_frame_change_detector: stimulus, flow control and verdict for frame_change_detector
// depends on fcd_pkg, frame_change_detector and fcd_frame_checker
`timescale 1ns / 1ps

module tb_frame_change_detector;
  import fcd_pkg::*;

  // index that maps to no register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // settle time after a drain, scaled from the result latency
  localparam int unsigned RESULT_LATENCY = 3;
  localparam int unsigned SETTLE_CYCLES  = 3 * RESULT_LATENCY;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned NUM_PHASES     = 9;
  localparam int unsigned PHASE_ITEMS    = 120;
  localparam int unsigned HOLD_FRAMES    = 40;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // before_pixel, after_pixel
  logic                   s_axis_tuser;   // sizes_differ
  logic                   s_axis_tlast;   // last_pixel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // frame_changed, changed_pixels,
                                          // sum_abs_delta, pixel_count, zero pad

  int unsigned pending_frames;
  int unsigned mismatch_count;

  // idle rates in percent for the sender and the receiver
  int unsigned tx_idle_pct = 22;
  int unsigned rx_idle_pct = 51;

  // receiver hold-off: the stimulus bumps the request, the receiver counts
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;

  // stimulus-side copy of pixel_delta, only used to aim pairs at the threshold
  logic [PIX_W-1:0] cur_pixel_delta;

  frame_change_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fcd_frame_checker u_frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending_frames),
    .mismatches_o  (mismatch_count)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random back-pressure, or a long hold when one is requested
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  <= rx_hold_left - 1;
    end else if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen  <= rx_hold_req;
      rx_hold_left  <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hard stop in case the block hangs or drops a result
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // one register write, only issued while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one pixel pair, with random idle cycles ahead of it
  task automatic push_pair(logic [PIX_W-1:0] before_px, logic [PIX_W-1:0] after_px,
                           logic differ, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {after_px, before_px};
    s_axis_tuser  <= differ;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and wait until every frame result has come back
  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_frames != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one frame of len pairs; the difference style is picked per frame
  task automatic send_frame(int unsigned len);
    int unsigned style;
    int          d;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] a;
    style = $urandom_range(3);
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0:       d = -1;                                      // unrelated pixels
        1:       d = int'(cur_pixel_delta) - 1 + $urandom_range(2); // around threshold
        2:       d = $urandom_range(3);                       // nearly static scene
        default: d = $urandom_range(200, 255);                // heavy change
      endcase
      if (d > 255) d = 255;
      if (d < 0) begin
        b = PIX_W'($urandom);
        a = PIX_W'($urandom);
      end else if ($urandom_range(1) != 0) begin
        b = PIX_W'($urandom_range(255 - d));
        a = b + PIX_W'(d);
      end else begin
        b = PIX_W'($urandom_range(255, d));
        a = b - PIX_W'(d);
      end
      // sizes_differ also shows up mid-frame, where it must be ignored
      push_pair(b, a, $urandom_range(7) == 0, i == len - 1);
    end
  endtask

  // register settings per phase, extremes first, then random ones
  task automatic configure_phase(int unsigned phase);
    logic [PIX_W-1:0]  pd;
    logic [CNT_W-1:0]  min_px;
    logic [MEAN_W-1:0] mean_q8;
    case (phase % 4)
      0: begin pd = '0;   min_px = '1;          mean_q8 = '0;  end
      1: begin pd = '1;   min_px = '0;          mean_q8 = '1;  end
      2: begin pd = PIX_W'($urandom); min_px = CNT_W'(4194304); mean_q8 = MEAN_DELTA_RST; end
      default: begin
        pd      = PIX_W'($urandom_range(40));
        min_px  = CNT_W'($urandom_range(1, 30));
        mean_q8 = MEAN_W'($urandom);
      end
    endcase
    // junk above the register width has to be dropped by the block
    write_reg(REG_PIXEL_DELTA, {CFG_W'($urandom) & ~CFG_W'({PIX_W{1'b1}})} | CFG_W'(pd));
    write_reg(REG_MIN_CHANGED, CFG_W'(min_px));
    write_reg(REG_MEAN_DELTA, {CFG_W'($urandom) & ~CFG_W'({MEAN_W{1'b1}})} | CFG_W'(mean_q8));
    cur_pixel_delta = pd;
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned len;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PIXEL_DELTA;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cur_pixel_delta = PIXEL_DELTA_RST;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames on the reset defaults: delta 16, min 1024, mean 5.0
    push_pair(8'd0, 8'd255, 1'b0, 1'b1);    // full-scale difference, mean fires
    push_pair(8'd255, 8'd0, 1'b0, 1'b1);    // same, other direction
    push_pair(8'd7, 8'd7, 1'b0, 1'b1);      // no change at all
    push_pair(8'd7, 8'd7, 1'b1, 1'b1);      // size mismatch forces the flag
    push_pair(8'd9, 8'd9, 1'b1, 1'b0);      // size mismatch mid-frame is ignored
    push_pair(8'd9, 8'd9, 1'b0, 1'b1);
    push_pair(8'd10, 8'd26, 1'b0, 1'b0);    // difference equal to delta, not changed
    push_pair(8'd30, 8'd13, 1'b0, 1'b1);    // one above delta, changed
    push_pair(8'd100, 8'd105, 1'b0, 1'b1);  // mean exactly at threshold, no flag
    push_pair(8'd100, 8'd106, 1'b0, 1'b1);  // mean just above
    drain_frames();

    // a write to an unmapped index changes nothing
    write_reg(REG_UNMAPPED, '1);
    push_pair(8'd100, 8'd105, 1'b0, 1'b1);
    drain_frames();

    // high junk bits on pixel_delta, and a zero minimum flags every frame
    write_reg(REG_PIXEL_DELTA, 23'h7FFF03);
    write_reg(REG_MIN_CHANGED, '0);
    cur_pixel_delta = 8'd3;
    push_pair(8'd50, 8'd50, 1'b0, 1'b1);
    push_pair(8'd0, 8'd4, 1'b0, 1'b0);
    push_pair(8'd4, 8'd1, 1'b0, 1'b1);
    drain_frames();

    // random phases: idle mix 22/51, then 51/22, then none
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      tx_idle_pct = (phase < 3) ? 22 : (phase < 6) ? 51 : 0;
      rx_idle_pct = (phase < 3) ? 51 : (phase < 6) ? 22 : 0;
      configure_phase(phase);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        send_frame(len);
        phase_items += len;
      end
      // back-pressure burst: receiver holds off while single-pair frames
      // keep coming, so the result path fills and input stalls
      if (phase == 2 || phase == 7) begin
        tx_idle_pct = 0;
        rx_hold_req++;
        for (int unsigned f = 0; f < HOLD_FRAMES; f++)
          send_frame(1);
      end
      drain_frames();
    end

    if (mismatch_count == 0 && pending_frames == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/fcd_pkg.sv
rtl/core/frame_change_detector.sv
rtl/core/fcd_port_checker.sv
dv/fcd_frame_checker.sv
dv/tb_frame_change_detector.sv
